// File: hw/rtl/prmw_pkg.sv
`timescale 1ns / 1ps

package prmw_pkg;

	localparam int MAX_READ_LEN_DEF = 256;
	localparam int MAX_WINDOW_DEF   = 32;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

	localparam int           WS_W        = 6;
	localparam logic [WS_W-1:0] WINDOW_RESET = 6'd17;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef enum logic [1:0] {
		CLS_READ1 = 2'd0,
		CLS_READ2 = 2'd1,
		CLS_BOTH  = 2'd2,
		CLS_NONE  = 2'd3
	} cls_t;

endpackage

// File: hw/rtl/prmw_front.sv
`timescale 1ns / 1ps

module prmw_front
	import prmw_pkg::*;
#(
	parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
	localparam int D     = MAX_WINDOW / 2 + 1,
	localparam int AGE_W = $clog2(D),
	localparam int POS_W = $clog2(MAX_READ_LEN)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [WS_W-1:0]     cfg_wdata,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [7:0]          first_read_base,
	input  logic [7:0]          second_read_base,
	input  logic [7:0]          reference_base,
	input  logic                end_of_read,
	output logic                push_valid,
	output logic [D-1:0]        push_mask,
	output cls_t [D-1:0]        push_cls,
	output logic [POS_W-1:0]    push_pos,
	output logic [AGE_W-1:0]    push_half,
	input  logic                queue_full
);

	localparam int K_W   = $clog2(MAX_WINDOW + 1);
	localparam int LEN_W = K_W + 1;
	localparam int CMP_W = ((POS_W > K_W) ? POS_W : K_W) + 2;
	localparam logic [K_W-1:0]   RUN_MAX = K_W'(MAX_WINDOW);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_READ_LEN - 1);

	logic [WS_W-1:0]  ws_q;
	logic [POS_W-1:0] pos_q;
	logic [K_W-1:0]   run1_q, run2_q, runa_q;
	cls_t [D-1:0]     pend_q;

	logic             valid_s1;
	logic             eor_s1;
	logic [POS_W-1:0] pos_s1;
	logic [K_W-1:0]   run1_s1, run2_s1, runa_s1;
	cls_t [D-1:0]     pend_s1;
	logic [AGE_W-1:0] half_s1, close_s1;

	logic [6:0]       k7, half7, close7;
	logic [AGE_W-1:0] half_c, close_c;
	logic [7:0]       ref_up;
	logic             m1, m2, ag;
	cls_t             cls_c;
	logic [K_W-1:0]   run1_n, run2_n, runa_n;
	cls_t [D-1:0]     pend_n;
	logic [D-1:0]     hit;
	logic             adv, accept;

	// effective window: zero acts as one, clamp at the top
	always_comb begin
		if (ws_q == '0) begin
			k7 = 7'd1;
		end else if ({1'b0, ws_q} > 7'(MAX_WINDOW)) begin
			k7 = 7'(MAX_WINDOW);
		end else begin
			k7 = {1'b0, ws_q};
		end
		half7  = k7 >> 1;
		close7 = k7 - half7 - 7'd1;
		half_c  = AGE_W'(half7);
		close_c = AGE_W'(close7);
	end

	always_comb begin
		if (reference_base >= CHAR_LOWER_A && reference_base <= CHAR_LOWER_Z) begin
			ref_up = reference_base - CASE_OFFSET;
		end else begin
			ref_up = reference_base;
		end
		m1 = (first_read_base == ref_up);
		m2 = (second_read_base == ref_up);
		ag = (first_read_base == second_read_base);
		if (m1 && !m2) begin
			cls_c = CLS_READ1;
		end else if (!m1 && m2) begin
			cls_c = CLS_READ2;
		end else if (!m1 && ag) begin
			cls_c = CLS_BOTH;
		end else begin
			cls_c = CLS_NONE;
		end
		run1_n = !m1 ? '0 : (run1_q >= RUN_MAX) ? RUN_MAX : run1_q + K_W'(1);
		run2_n = !m2 ? '0 : (run2_q >= RUN_MAX) ? RUN_MAX : run2_q + K_W'(1);
		runa_n = !ag ? '0 : (runa_q >= RUN_MAX) ? RUN_MAX : runa_q + K_W'(1);
		pend_n = {pend_q[D-2:0], cls_c};
	end

	// judge every age in parallel against the snapshot taken at accept
	always_comb begin
		logic [AGE_W-1:0] age;
		logic             range_ok, pos_ok, run_ok;
		logic [K_W-1:0]   run_sel;
		logic [LEN_W-1:0] need;
		for (int a = 0; a < D; a++) begin
			age      = AGE_W'(a);
			range_ok = (age <= close_s1) && (eor_s1 || age == close_s1);
			pos_ok   = CMP_W'(pos_s1) >= CMP_W'(age) + CMP_W'({half_s1, 1'b0});
			case (pend_s1[a])
				CLS_READ1: run_sel = run1_s1;
				CLS_READ2: run_sel = run2_s1;
				default:   run_sel = runa_s1;
			endcase
			need   = LEN_W'(age) + LEN_W'(half_s1) + LEN_W'(1);
			run_ok = LEN_W'(run_sel) >= need;
			hit[a] = (pend_s1[a] != CLS_NONE) && range_ok && pos_ok && run_ok;
		end
	end

	assign adv        = !valid_s1 || !(|hit) || !queue_full;
	assign accept     = item_valid && adv;
	assign item_stall = !adv;

	assign push_valid = valid_s1 && (|hit) && !queue_full;
	assign push_mask  = hit;
	assign push_cls   = pend_s1;
	assign push_pos   = pos_s1;
	assign push_half  = half_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q     <= WINDOW_RESET;
			pos_q    <= '0;
			run1_q   <= '0;
			run2_q   <= '0;
			runa_q   <= '0;
			pend_q   <= {D{CLS_NONE}};
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			if (adv) begin
				valid_s1 <= accept;
			end
			if (accept) begin
				if (end_of_read) begin
					pos_q  <= '0;
					run1_q <= '0;
					run2_q <= '0;
					runa_q <= '0;
					pend_q <= {D{CLS_NONE}};
				end else begin
					pos_q  <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
					run1_q <= run1_n;
					run2_q <= run2_n;
					runa_q <= runa_n;
					pend_q <= pend_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eor_s1   <= end_of_read;
			pos_s1   <= pos_q;
			run1_s1  <= run1_n;
			run2_s1  <= run2_n;
			runa_s1  <= runa_n;
			pend_s1  <= pend_n;
			half_s1  <= half_c;
			close_s1 <= close_c;
		end
	end

endmodule

// File: hw/rtl/prmw_queue.sv
`timescale 1ns / 1ps

module prmw_queue
	import prmw_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] data
);

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/prmw_back.sv
`timescale 1ns / 1ps

module prmw_back
	import prmw_pkg::*;
#(
	parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
	localparam int D     = MAX_WINDOW / 2 + 1,
	localparam int AGE_W = $clog2(D),
	localparam int POS_W = $clog2(MAX_READ_LEN)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [D-1:0]     q_mask,
	input  cls_t [D-1:0]     q_cls,
	input  logic [POS_W-1:0] q_pos,
	input  logic [AGE_W-1:0] q_half,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [1:0]       event_class,
	output logic [7:0]       window_start,
	output logic [5:0]       window_length,
	output logic             last_result
);

	logic             wvalid_q;
	logic [D-1:0]     wmask_q;
	cls_t [D-1:0]     wcls_q;
	logic [POS_W-1:0] wpos_q;
	logic [AGE_W-1:0] whalf_q;

	logic             ovalid_q;
	logic [1:0]       class_q;
	logic [7:0]       start_q;
	logic [5:0]       length_q;
	logic             last_q;

	logic [AGE_W-1:0] sel;
	logic [D-1:0]     rest;
	logic             out_free, emit, rest_empty;
	logic [POS_W-1:0] st;
	logic [6:0]       len7;

	// oldest pending window first: highest set age
	always_comb begin
		sel = '0;
		for (int a = 0; a < D; a++) begin
			if (wmask_q[a]) begin
				sel = AGE_W'(a);
			end
		end
		rest       = wmask_q & ~(D'(1) << sel);
		rest_empty = (rest == '0);
		st         = wpos_q - POS_W'(sel) - POS_W'(whalf_q);
		len7       = 7'(sel) + 7'(whalf_q) + 7'd1;
	end

	assign out_free = !ovalid_q || !result_stall;
	assign emit     = wvalid_q && out_free;
	assign pop      = q_valid && (!wvalid_q || (emit && rest_empty));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				wvalid_q <= 1'b1;
			end else if (emit && rest_empty) begin
				wvalid_q <= 1'b0;
			end
			if (out_free) begin
				ovalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wmask_q <= q_mask;
			wcls_q  <= q_cls;
			wpos_q  <= q_pos;
			whalf_q <= q_half;
		end else if (emit) begin
			wmask_q <= rest;
		end
		if (emit) begin
			class_q  <= wcls_q[sel];
			start_q  <= 8'(st);
			length_q <= 6'(len7);
			last_q   <= rest_empty;
		end
	end

	assign result_valid  = ovalid_q;
	assign event_class   = class_q;
	assign window_start  = start_q;
	assign window_length = length_q;
	assign last_result   = last_q;

endmodule

// File: hw/rtl/paired_read_mismatch_window_filter.sv
`timescale 1ns / 1ps
// Result path: stage-one register, queue, working register, then result register.
// Throughput: one item per cycle while item_stall is low; the back end issues one
//   result per cycle while result_stall is low, so an end-of-read item with n
//   results holds the back end until all n are issued, and the four-entry queue
//   absorbs that before the front end stalls.
// Reset: arst_n clears position, runs, pending candidates, queue and valids,
//   and loads a window size of 17.
module paired_read_mismatch_window_filter
	import prmw_pkg::*;
#(
	parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [WS_W-1:0] cfg_wdata,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic [7:0]      first_read_base,
	input  logic [7:0]      second_read_base,
	input  logic [7:0]      reference_base,
	input  logic            end_of_read,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [1:0]      event_class,
	output logic [7:0]      window_start,
	output logic [5:0]      window_length,
	output logic            last_result
);

	localparam int D     = MAX_WINDOW / 2 + 1;
	localparam int AGE_W = $clog2(D);
	localparam int POS_W = $clog2(MAX_READ_LEN);
	localparam int QW    = D + 2 * D + POS_W + AGE_W;

	logic             push_valid, queue_full, q_valid, pop;
	logic [D-1:0]     push_mask, q_mask;
	cls_t [D-1:0]     push_cls, q_cls;
	logic [POS_W-1:0] push_pos, q_pos;
	logic [AGE_W-1:0] push_half, q_half;
	logic [QW-1:0]    push_data, q_data;

	prmw_front #(
		.MAX_READ_LEN (MAX_READ_LEN),
		.MAX_WINDOW   (MAX_WINDOW)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.first_read_base  (first_read_base),
		.second_read_base (second_read_base),
		.reference_base   (reference_base),
		.end_of_read      (end_of_read),
		.push_valid       (push_valid),
		.push_mask        (push_mask),
		.push_cls         (push_cls),
		.push_pos         (push_pos),
		.push_half        (push_half),
		.queue_full       (queue_full)
	);

	assign push_data = {push_mask, push_cls, push_pos, push_half};

	prmw_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	assign {q_mask, q_cls, q_pos, q_half} = q_data;

	prmw_back #(
		.MAX_READ_LEN (MAX_READ_LEN),
		.MAX_WINDOW   (MAX_WINDOW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_mask        (q_mask),
		.q_cls         (q_cls),
		.q_pos         (q_pos),
		.q_half        (q_half),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.event_class   (event_class),
		.window_start  (window_start),
		.window_length (window_length),
		.last_result   (last_result)
	);

endmodule

// File: hw/rtl/prmw_checker.sv
`timescale 1ns / 1ps

module prmw_checker
	import prmw_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] event_class,
	input logic [7:0] window_start,
	input logic [5:0] window_length,
	input logic       last_result
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(event_class)
			&& $stable(window_start) && $stable(window_length) && $stable(last_result))
		else $error("stalled result changed");

	a_class_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> event_class != CLS_NONE)
		else $error("result carries no-candidate class");

	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> window_length != 6'd0)
		else $error("result with empty window");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result_valid && !item_stall)
		else $error("activity right after reset");

endmodule

bind paired_read_mismatch_window_filter prmw_checker u_prmw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_stall    (item_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.event_class   (event_class),
	.window_start  (window_start),
	.window_length (window_length),
	.last_result   (last_result)
);
